>>> rtl/core/mlws_pkg.sv
package mlws_pkg;

   localparam int WEIGHT_W = 20;
   localparam int TARGET_W = 30;
   localparam int SUM_W    = 32;
   localparam int LEN_W    = 13;

   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1);

   // input item
   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                last_item;
   } req_type;

   // result item
   typedef struct packed {
      logic             found;
      logic [LEN_W-1:0] min_length;
      logic             overflow;
   } rsp_type;

   // shared adder operation
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // control from the sequencer to the shared unit
   typedef struct packed {
      alu_op_type          op;
      logic [SUM_W-1:0]    operand;
   } alu_ctl_type;

endpackage

>>> rtl/core/mlws_store.sv
module mlws_store
   import mlws_pkg::*;
   #(parameter int DEPTH = 4096,
     parameter int AW    = 12)
   (input  logic                clock,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [WEIGHT_W-1:0] wr_data,
    input  logic [AW-1:0]       rd_addr,
    output logic [WEIGHT_W-1:0] rd_data);

   logic [WEIGHT_W-1:0] mem [DEPTH];
   logic [WEIGHT_W-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mlws_alu.sv
module mlws_alu
   import mlws_pkg::*;
   (input  logic [SUM_W-1:0]    sum,
    input  alu_ctl_type         ctl,
    input  logic [TARGET_W-1:0] target,
    output logic [SUM_W-1:0]    result,
    output logic                reached);

   // shared add / subtract on the window sum
   always_comb begin
      case (ctl.op)
         ALU_ADD: result = sum + ctl.operand;
         ALU_SUB: result = sum - ctl.operand;
         default: result = sum;
      endcase
   end

   // threshold compare on the current sum
   assign reached = (sum >= SUM_W'(target));

endmodule

>>> rtl/core/min_length_window_sum_core.sv
// channel  | ports                         | direction | role
// ---------+-------------------------------+-----------+-----------------------------
// req      | req_valid req_stall req_payload | in      | weight and last-item mark
// rsp      | rsp_valid rsp_stall rsp_payload | out     | found, min_length, overflow
// csr      | csr_wr_en csr_wr_data         | in        | target_sum register
//
// an item is handled by adding the weight and then a compare, and each window shrink
// step adds a compare with a store read, then a subtract
// reset is synchronous: it clears the sequencer, counters and result valid flag and
// returns target_sum to 1; the item store is not cleared
// the result register holds while rsp_stall is high and new items are taken meanwhile;
// a later last item waits in the compare step until the result is taken
module min_length_window_sum_core
   import mlws_pkg::*;
   #(parameter int MAX_ITEMS = 4096)
   (input  logic                clock,
    input  logic                reset,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_type             req_payload,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_type             rsp_payload,
    input  logic                csr_wr_en,
    input  logic [TARGET_W-1:0] csr_wr_data);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ITEMS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUB
   } state_type;

   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      best_ff, best_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;
   logic [TARGET_W-1:0] target_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   alu_ctl_type        alu_ctl;
   logic [SUM_W-1:0]   alu_result;
   logic               alu_reached;
   logic [WEIGHT_W-1:0] rd_data;
   logic               accept;
   logic               full;
   logic               store_wr;
   logic               shrink;
   logic [CW-1:0]      win_len;

   assign accept   = req_valid && !req_stall;
   assign full     = (count_ff >= COUNT_MAX);
   assign store_wr = accept && !full;
   assign shrink   = (left_ff < count_ff) && alu_reached;
   assign win_len  = count_ff - left_ff;

   mlws_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_payload.weight),
      .rd_addr (left_ff[AW-1:0]),
      .rd_data (rd_data));

   // operand select for the shared unit
   always_comb begin
      if (state_ff == ST_SUB) begin
         alu_ctl.op      = ALU_SUB;
         alu_ctl.operand = SUM_W'(rd_data);
      end else begin
         alu_ctl.op      = ALU_ADD;
         alu_ctl.operand = SUM_W'(req_payload.weight);
      end
   end

   mlws_alu u_alu (
      .sum     (sum_ff),
      .ctl     (alu_ctl),
      .target  (target_ff),
      .result  (alu_result),
      .reached (alu_reached));

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      left_in      = left_ff;
      count_in     = count_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in  = req_payload.last_item;
               state_in = ST_CHECK;
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  sum_in   = alu_result;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_CHECK: begin
            if (shrink) begin
               if (best_ff == '0 || win_len < best_ff) begin
                  best_in = win_len;
               end
               state_in = ST_SUB;
            end else if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               // emit and clear for the next sequence
               rsp_valid_in      = 1'b1;
               rsp_in.found      = (best_ff != '0);
               rsp_in.min_length = LEN_W'(best_ff);
               rsp_in.overflow   = ovf_ff;
               sum_in   = '0;
               left_in  = '0;
               count_in = '0;
               best_in  = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_SUB: begin
            sum_in   = alu_result;
            left_in  = left_ff + CW'(1);
            state_in = ST_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         left_ff      <= '0;
         count_ff     <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         left_ff      <= left_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // target register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/core/mlws_checker.sv
module mlws_checker
   import mlws_pkg::*;
   #(parameter int MAX_ITEMS = 4096)
   (input logic    clock,
    input logic    reset,
    input logic    req_valid,
    input logic    req_stall,
    input logic    rsp_valid,
    input logic    rsp_stall,
    input rsp_type rsp_payload);

   localparam logic [31:0] LEN_LIMIT = 32'(MAX_ITEMS);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // no window found means a zero length
   a_not_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.min_length == '0)
      else $error("length without a found window");

   // length never exceeds the store depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_payload.min_length) <= LEN_LIMIT)
      else $error("length beyond store depth");

   // the block is busy in the cycle after a transfer
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("ready right after a transfer");

   // reset empties the result register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind min_length_window_sum_core mlws_checker #(.MAX_ITEMS(MAX_ITEMS)) u_mlws_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload));

>>> dv/tb_top.sv
module tb_top
   import mlws_pkg::*;
   ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH   = 4096;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int RANDOM_PHASES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [TARGET_W-1:0]  TARGET_MAX = '1;
   localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX = '1;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_wr_en   = 1'b0;
   logic [TARGET_W-1:0] csr_wr_data = '0;

   min_length_window_sum_core #(.MAX_ITEMS(STORE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data));

   // one row of the directed sequence
   typedef struct {
      bit                  set_target;
      logic [TARGET_W-1:0] target;
      req_type             item;
      bit                  typed;
      rsp_type             outcome;
   } directed_row_type;

   directed_row_type directed_rows[$];

   // window predictor state
   logic [WEIGHT_W-1:0] held_weights [STORE_DEPTH];
   logic [SUM_W-1:0]    window_total  = '0;
   int                  window_start  = 0;
   int                  items_held    = 0;
   int                  best_len      = 0;
   bit                  overflow_seen = 1'b0;
   logic [TARGET_W-1:0] target_sum    = TARGET_RESET;

   rsp_type outcomes_due[$];
   int      mismatch_count = 0;

   // traffic shaping shared by both sides
   bit steady        = 1'b0;
   bit long_hold_req = 1'b0;
   bit hold_taken    = 1'b0;
   int hold_left     = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] %s", $realtime, msg);
      mismatch_count++;
   endtask

   // add one weight to the window and return the result a last item closes
   function automatic bit predict_window(input req_type item, output rsp_type outcome);
      int len;
      outcome = '0;
      if (items_held >= STORE_DEPTH) begin
         overflow_seen = 1'b1;
      end else begin
         held_weights[items_held] = item.weight;
         items_held++;
         window_total += SUM_W'(item.weight);
         // shrink from the left while the window still meets the target
         while (window_start < items_held && window_total >= SUM_W'(target_sum)) begin
            len = items_held - window_start;
            if (best_len == 0 || len < best_len)
               best_len = len;
            window_total -= SUM_W'(held_weights[window_start]);
            window_start++;
         end
      end
      if (!item.last_item)
         return 1'b0;
      outcome.found      = (best_len != 0);
      outcome.min_length = LEN_W'(best_len);
      outcome.overflow   = overflow_seen;
      window_total  = '0;
      window_start  = 0;
      items_held    = 0;
      best_len      = 0;
      overflow_seen = 1'b0;
      return 1'b1;
   endfunction

   task automatic add_row(input bit set_t, input logic [TARGET_W-1:0] t,
                          input logic [WEIGHT_W-1:0] w, input bit last,
                          input bit typed, input bit found, input int len, input bit ovf);
      directed_row_type row;
      row.set_target         = set_t;
      row.target             = t;
      row.item.weight        = w;
      row.item.last_item     = last;
      row.typed              = typed;
      row.outcome.found      = found;
      row.outcome.min_length = LEN_W'(len);
      row.outcome.overflow   = ovf;
      directed_rows.push_back(row);
   endtask

   // offer one item, with a random gap in front, and predict on transfer
   task automatic send_item(input req_type item, input bit typed, input rsp_type given);
      rsp_type predicted;
      if (!steady && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_window(item, predicted))
         outcomes_due.push_back(typed ? given : predicted);
   endtask

   // stop offering and wait for every due result, then let the block settle
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (outcomes_due.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_W-1:0] t);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      target_sum   = t;
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight(input logic [WEIGHT_W-1:0] cap);
      int r;
      r = $urandom_range(9);
      if (r == 0)
         return '0;
      if (r == 1)
         return WEIGHT_MAX;
      return WEIGHT_W'($urandom_range(0, int'(cap)));
   endfunction

   // result side: check each transfer, then choose the next stall
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcomes_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing due: found %0b len %0d ovf %0b",
                  rsp_payload.found, rsp_payload.min_length, rsp_payload.overflow));
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_payload.found !== want.found)
                  report_mismatch($sformatf("found: got %0b, want %0b",
                     rsp_payload.found, want.found));
               if (rsp_payload.min_length !== want.min_length)
                  report_mismatch($sformatf("min_length: got %0d, want %0d",
                     rsp_payload.min_length, want.min_length));
               if (rsp_payload.overflow !== want.overflow)
                  report_mismatch($sformatf("overflow: got %0b, want %0b",
                     rsp_payload.overflow, want.overflow));
            end
         end
         // one long hold-off, otherwise random stalls
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 23);
         end
      end
   end

   // stimulus
   initial begin
      req_type             item;
      rsp_type             none;
      rsp_type             typed_out;
      logic [TARGET_W-1:0] t;
      logic [WEIGHT_W-1:0] cap;
      int                  sent;
      int                  seq_len;

      none = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset target, zero weight, extremes, zero target, shrink paths
      add_row(0, '0, 1, 1, 1, 1, 1, 0);
      add_row(0, '0, 0, 1, 1, 0, 0, 0);
      add_row(1, TARGET_MAX, WEIGHT_MAX, 0, 0, 0, 0, 0);
      add_row(0, '0, WEIGHT_MAX, 1, 1, 0, 0, 0);
      add_row(1, '0, 5, 0, 0, 0, 0, 0);
      add_row(0, '0, 0, 0, 0, 0, 0, 0);
      add_row(0, '0, 7, 1, 1, 1, 1, 0);
      add_row(1, 10, 3, 0, 0, 0, 0, 0);
      add_row(0, '0, 3, 0, 0, 0, 0, 0);
      add_row(0, '0, 3, 0, 0, 0, 0, 0);
      add_row(0, '0, 3, 1, 0, 0, 0, 0);
      add_row(0, '0, 2, 0, 0, 0, 0, 0);
      add_row(0, '0, 8, 0, 0, 0, 0, 0);
      add_row(0, '0, 1, 0, 0, 0, 0, 0);
      add_row(0, '0, 1, 0, 0, 0, 0, 0);
      add_row(0, '0, 9, 1, 0, 0, 0, 0);
      add_row(1, TARGET_W'(2) * TARGET_W'(WEIGHT_MAX), WEIGHT_MAX, 0, 0, 0, 0, 0);
      add_row(0, '0, 0, 0, 0, 0, 0, 0);
      add_row(0, '0, WEIGHT_MAX, 1, 0, 0, 0, 0);
      add_row(0, '0, 20'hAAAAA, 0, 0, 0, 0, 0);
      add_row(0, '0, 20'h55555, 1, 0, 0, 0, 0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_target) begin
            drain(SETTLE_CYCLES);
            write_target(directed_rows[i].target);
         end
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].outcome);
      end

      // store full: only the whole store reaches the target
      drain(SETTLE_CYCLES);
      write_target(TARGET_W'(STORE_DEPTH));
      typed_out.found      = 1'b1;
      typed_out.min_length = LEN_W'(STORE_DEPTH);
      typed_out.overflow   = 1'b1;
      for (int k = 0; k < STORE_DEPTH + 3; k++) begin
         item.weight    = 1;
         item.last_item = (k == STORE_DEPTH + 2);
         send_item(item, item.last_item, typed_out);
      end

      // store full with the target never reached
      drain(SETTLE_CYCLES);
      write_target(TARGET_MAX);
      typed_out = '0;
      typed_out.overflow = 1'b1;
      for (int k = 0; k < STORE_DEPTH + 4; k++) begin
         item.weight    = 1;
         item.last_item = (k == STORE_DEPTH + 3);
         send_item(item, item.last_item, typed_out);
      end

      // random sequences, one target per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain(SETTLE_CYCLES);
         case (p)
            0: begin
               t   = TARGET_W'($urandom_range(1, 40));
               cap = 15;
            end
            1: begin
               t   = TARGET_W'($urandom_range(1, 2000));
               cap = 1023;
            end
            2: begin
               t   = TARGET_W'($urandom_range(1, 1 << 26));
               cap = WEIGHT_MAX;
            end
            3: begin
               t   = 1;
               cap = 3;
            end
            4: begin
               t   = '0;
               cap = WEIGHT_MAX;
            end
            default: begin
               t   = TARGET_W'($urandom) | TARGET_W'(1);
               cap = WEIGHT_MAX;
            end
         endcase
         write_target(t);
         // no idling on either side for one whole phase
         steady = (p == 2);
         // receiver holds off for a long stretch while items keep coming
         if (p == 1)
            long_hold_req = 1'b1;
         sent = 0;
         while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
            seq_len = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
            for (int k = 0; k < seq_len; k++) begin
               item.weight    = pick_weight(cap);
               item.last_item = (k == seq_len - 1);
               send_item(item, 1'b0, none);
               sent++;
            end
            // now and then wait for every due result before going on
            if ($urandom_range(19) == 0)
               drain(0);
         end
      end
      steady = 1'b0;

      drain(SETTLE_CYCLES);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
